>>> rtl/pbc_pkg.sv
// Shared constants and types for the pixel background compositor.
`timescale 1ns / 1ps

package pbc_pkg;

  localparam int FIELD_W            = 16;
  localparam int QUOT_W             = 16;
  localparam int TRANS_W            = 17;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 16;
  localparam int DEF_FRACTION_BITS  = 15;

  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_RED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_GREEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_BLUE  = 2'd3;

  // Per-lane decisions that travel alongside the divider stages.
  typedef struct packed {
    logic                transparent;
    logic                alpha_zero;
    logic                overflow;
    logic [FIELD_W-1:0]  blend;
  } pbc_side_t;

endpackage

>>> rtl/pbc_div.sv
// Pipelined restoring divider that yields one quotient bit per stage.
`timescale 1ns / 1ps

module pbc_div
  import pbc_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                               clk,
  input  logic [FIELD_W+FRACTION_BITS:0]     num,
  input  logic [FRACTION_BITS:0]             den,
  output logic [QUOT_W-1:0]                  quo
);

  localparam int NW = FIELD_W + FRACTION_BITS + 1;
  localparam int DW = FRACTION_BITS + 1;

  logic [NW-1:0]     rem_s [QUOT_W-1];
  logic [DW-1:0]     den_s [QUOT_W-1];
  logic [QUOT_W-1:0] quo_s [QUOT_W];

  genvar k;
  generate
    for (k = 0; k < QUOT_W; k++) begin : g_stage
      localparam int SH = QUOT_W - 1 - k;
      logic [NW-1:0]     rem_in;
      logic [DW-1:0]     den_in;
      logic [QUOT_W-1:0] quo_in;
      logic [NW-1:0]     dsh;
      logic              take;

      if (k == 0) begin : g_first
        assign rem_in = num;
        assign den_in = den;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_s[k-1];
        assign den_in = den_s[k-1];
        assign quo_in = quo_s[k-1];
      end

      assign dsh  = NW'(den_in) << SH;
      assign take = (rem_in >= dsh);

      always_ff @(posedge clk) begin
        quo_s[k] <= take ? (quo_in | (QUOT_W'(1) << SH)) : quo_in;
      end

      if (k < QUOT_W - 1) begin : g_rem
        always_ff @(posedge clk) begin
          rem_s[k] <= take ? (rem_in - dsh) : rem_in;
          den_s[k] <= den_in;
        end
      end
    end
  endgenerate

  assign quo = quo_s[QUOT_W-1];

endmodule

>>> rtl/pbc_lane.sv
// One color lane: background blend and unpremultiply, with result select.
`timescale 1ns / 1ps

module pbc_lane
  import pbc_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       transparent,
  input  logic [FIELD_W-1:0]         color,
  input  logic [FRACTION_BITS:0]     trans,
  input  logic [FRACTION_BITS:0]     alpha,
  input  logic [FIELD_W-1:0]         background,
  output logic [FIELD_W-1:0]         result
);

  localparam int NW = FIELD_W + FRACTION_BITS + 1;
  localparam int DW = FRACTION_BITS + 1;
  localparam int PW = DW + FIELD_W + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);
  localparam int SIDE_D = QUOT_W;

  logic [NW-1:0]      num1;
  logic [PW-1:0]      prod1;
  logic [FIELD_W-1:0] color1;
  logic [DW-1:0]      alpha1;
  logic               transparent1;

  logic [PW-1:0]      blend_sum;
  pbc_side_t          side_next;
  pbc_side_t          side_d [SIDE_D];
  logic [QUOT_W-1:0]  quo;

  // First stage: the dividend with its rounding term, and the blend product.
  always_ff @(posedge clk) begin
    num1         <= (NW'(color) << FRACTION_BITS) + NW'(alpha >> 1);
    prod1        <= PW'(trans) * PW'(background);
    color1       <= color;
    alpha1       <= alpha;
    transparent1 <= transparent;
  end

  assign blend_sum = PW'(color1) + ((prod1 + HALF) >> FRACTION_BITS);

  always_comb begin
    side_next.transparent = transparent1;
    side_next.alpha_zero  = (alpha1 == '0);
    // A quotient at or above 2^16 saturates; the divider bits are then ignored.
    side_next.overflow    = (num1 >= (NW'(alpha1) << QUOT_W));
    side_next.blend       = (blend_sum > PW'({FIELD_W{1'b1}})) ? '1 : blend_sum[FIELD_W-1:0];
  end

  pbc_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk(clk),
    .num(num1),
    .den(alpha1),
    .quo(quo)
  );

  genvar k;
  generate
    for (k = 0; k < SIDE_D; k++) begin : g_side
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          side_d[k] <= side_next;
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          side_d[k] <= side_d[k-1];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!side_d[SIDE_D-1].transparent) begin
      result <= side_d[SIDE_D-1].blend;
    end else if (side_d[SIDE_D-1].alpha_zero) begin
      result <= '0;
    end else if (side_d[SIDE_D-1].overflow) begin
      result <= '1;
    end else begin
      result <= quo;
    end
  end

endmodule

>>> rtl/pixel_background_composite.sv
// Top level of the pixel background compositor.
`timescale 1ns / 1ps

// Usage:
//   A pixel is taken at a rising edge with start high and busy low. busy is
//   high only in reset and the cycle after, so one pixel may enter every clock.
//   Each pixel produces one result, shown on the result ports for exactly one
//   cycle while done is high; results leave in the order pixels entered.
//   A pixel passes the input register, the lane first stage, the divider
//   stages, the lane result register and the output register. The three
//   color lanes each hold a pipelined restoring divider that retires one
//   quotient bit per stage, and that divider sets the depth.
//   Throughput is one pixel per clock.
//   Configuration registers are written through cfg_write, cfg_index and
//   cfg_data and take effect for pixels that enter afterwards; write them only
//   while no pixel is in flight.
//   Synchronous reset clears the configuration registers and drops every
//   pixel in flight. The receiver cannot stall: done is a strobe.
module pixel_background_composite
  import pbc_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [FIELD_W-1:0]    red_in,
  input  logic [FIELD_W-1:0]    green_in,
  input  logic [FIELD_W-1:0]    blue_in,
  input  logic [TRANS_W-1:0]    transmittance_in,
  input  logic                  last_in,
  output logic                  done,
  output logic [FIELD_W-1:0]    red_out,
  output logic [FIELD_W-1:0]    green_out,
  output logic [FIELD_W-1:0]    blue_out,
  output logic [FIELD_W-1:0]    alpha_out,
  output logic                  last_out
);

  localparam int DW       = FRACTION_BITS + 1;
  localparam int LANE_LAT = QUOT_W + 2;
  localparam logic [31:0] ONE_32 = 32'(1) << FRACTION_BITS;

  logic                 transparent_mode;
  logic [FIELD_W-1:0]   background_red;
  logic [FIELD_W-1:0]   background_green;
  logic [FIELD_W-1:0]   background_blue;

  logic                 accept;
  logic [31:0]          trans_wide;
  logic [31:0]          trans_clamp;
  logic [DW-1:0]        trans_next;
  logic [DW-1:0]        alpha_next;
  logic [31:0]          alpha_wide;

  logic                 valid0;
  logic [FIELD_W-1:0]   red0;
  logic [FIELD_W-1:0]   green0;
  logic [FIELD_W-1:0]   blue0;
  logic [DW-1:0]        trans0;
  logic [DW-1:0]        alpha0;
  logic                 mode0;
  logic                 last0;
  logic [FIELD_W-1:0]   alpha_res0;

  logic                 valid_d  [LANE_LAT];
  logic                 last_d   [LANE_LAT];
  logic                 mode_d   [LANE_LAT];
  logic [FIELD_W-1:0]   alpha_d  [LANE_LAT];
  logic                 out_mode;

  logic [FIELD_W-1:0]   red_res;
  logic [FIELD_W-1:0]   green_res;
  logic [FIELD_W-1:0]   blue_res;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transparent_mode <= 1'b0;
      background_red   <= '0;
      background_green <= '0;
      background_blue  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TRANSPARENT_MODE: transparent_mode <= cfg_data[0];
        REG_BACKGROUND_RED:   background_red   <= cfg_data;
        REG_BACKGROUND_GREEN: background_green <= cfg_data;
        REG_BACKGROUND_BLUE:  background_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A negative transmittance clamps to zero, one above unity clamps to unity.
  assign trans_wide  = 32'(transmittance_in[TRANS_W-2:0]);
  assign trans_clamp = transmittance_in[TRANS_W-1] ? 32'd0 :
                       ((trans_wide > ONE_32) ? ONE_32 : trans_wide);
  assign trans_next  = DW'(trans_clamp);
  assign alpha_next  = DW'(ONE_32 - trans_clamp);

  assign alpha_wide  = 32'(alpha0);
  assign alpha_res0  = !mode0 ? '0 :
                       ((alpha_wide > 32'(16'hFFFF)) ? '1 : alpha_wide[FIELD_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else begin
      valid0 <= accept;
    end
    red0   <= red_in;
    green0 <= green_in;
    blue0  <= blue_in;
    trans0 <= trans_next;
    alpha0 <= alpha_next;
    mode0  <= transparent_mode;
    last0  <= last_in;
  end

  pbc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_red (
    .clk(clk), .transparent(mode0), .color(red0), .trans(trans0),
    .alpha(alpha0), .background(background_red), .result(red_res)
  );

  pbc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_green (
    .clk(clk), .transparent(mode0), .color(green0), .trans(trans0),
    .alpha(alpha0), .background(background_green), .result(green_res)
  );

  pbc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_blue (
    .clk(clk), .transparent(mode0), .color(blue0), .trans(trans0),
    .alpha(alpha0), .background(background_blue), .result(blue_res)
  );

  // Per-pixel side data follows the lanes through a matching delay line.
  genvar k;
  generate
    for (k = 0; k < LANE_LAT; k++) begin : g_delay
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (rst) begin
            valid_d[k] <= 1'b0;
          end else begin
            valid_d[k] <= valid0;
          end
          last_d[k]  <= last0;
          mode_d[k]  <= mode0;
          alpha_d[k] <= alpha_res0;
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (rst) begin
            valid_d[k] <= 1'b0;
          end else begin
            valid_d[k] <= valid_d[k-1];
          end
          last_d[k]  <= last_d[k-1];
          mode_d[k]  <= mode_d[k-1];
          alpha_d[k] <= alpha_d[k-1];
        end
      end
    end
  endgenerate

  // Merge the three lanes with the side data into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_d[LANE_LAT-1];
    end
    red_out   <= red_res;
    green_out <= green_res;
    blue_out  <= blue_res;
    alpha_out <= alpha_d[LANE_LAT-1];
    last_out  <= last_d[LANE_LAT-1];
    out_mode  <= mode_d[LANE_LAT-1];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(LANE_LAT + 2) done)
    else $error("accepted pixel did not produce a result on time");

  a_opaque_alpha: assert property (@(posedge clk) disable iff (rst)
    (done && !out_mode) |-> (alpha_out == '0))
    else $error("opaque result carries a nonzero alpha");

  a_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    (done && out_mode && alpha_out == '0) |->
      (red_out == '0 && green_out == '0 && blue_out == '0))
    else $error("transparent result with zero alpha has nonzero color");

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(alpha_out) <= ONE_32 || alpha_out == '1))
    else $error("alpha result exceeds unity");

endmodule
